FILE: design/pidpi_pkg.sv
// Package for the PID position/incremental unit: field widths, register indexes,
// the configuration record and its reset values.
// No dependencies; every other design file refers to it by scoped names.
package pidpi_pkg;

    localparam int GAIN_W     = 16;
    localparam int DRIVE_W    = 16;
    localparam int INTEG_W    = 32;
    localparam int ILIM_W     = 31;
    localparam int PLIM_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_GAIN_P      = 3'd1,
        CFG_GAIN_I      = 3'd2,
        CFG_GAIN_D      = 3'd3,
        CFG_INTEG_LIMIT = 3'd4,
        CFG_POS_LIMIT   = 3'd5,
        CFG_INC_HIGH    = 3'd6,
        CFG_INC_LOW     = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic [ILIM_W-1:0]         integ_limit;
        logic [PLIM_W-1:0]         pos_limit;
        logic signed [DRIVE_W-1:0] inc_high;
        logic signed [DRIVE_W-1:0] inc_low;
    } cfg_t;

    localparam logic [PLIM_W-1:0]         POS_LIMIT_RST = 15'd6000;
    localparam logic signed [DRIVE_W-1:0] INC_HIGH_RST  = 16'sd5000;
    localparam logic signed [DRIVE_W-1:0] INC_LOW_RST   = -16'sd3000;

endpackage

FILE: design/pidpi_channels.sv
// Handshake channels of the PID unit: error samples in, drive values out and
// register writes. Depends on pidpi_pkg for the fixed field widths.
interface pidpi_sample_if #(parameter int ERROR_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [ERROR_WIDTH-1:0] error;

    modport source (output valid, output error, input ready);
    modport sink   (input valid, input error, output ready);
endinterface

interface pidpi_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pidpi_pkg::DRIVE_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

interface pidpi_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pidpi_pkg::CFG_IDX_W-1:0]   index;
    logic [pidpi_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/pid_position_incremental_unit.sv
// PID controller, positional or incremental, one error sample per beat.
// A sample beat passes the state, product and output registers in turn before its
// drive beat is offered; a stalled result channel can hold it between them.
// Throughput: one sample per cycle; only a stalled result channel slows intake.
// The critical loop is the output stage: held output plus terms, then the clamp.
// Reset (rst_n, asynchronous, active low) clears integrator, previous sample, held
// output and pipeline valids, and loads the register reset values.
module pid_position_incremental_unit #(
    parameter int FRAC_BITS   = 8,
    parameter int ERROR_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    pidpi_cfg_if.sink       cfg,
    pidpi_sample_if.sink    sample,
    pidpi_result_if.source  result
);

    localparam int PA_W = pidpi_pkg::GAIN_W + ERROR_WIDTH + 1;
    localparam int PB_W = pidpi_pkg::GAIN_W + pidpi_pkg::INTEG_W;

    pidpi_pkg::cfg_t regs;

    // Pipeline occupancy: stage 1 holds the registered sample, stage 2 the scaled
    // products, stage 3 the drive value on the result channel.
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic en1;
    logic en2;
    logic en3;
    logic accept;

    logic signed [ERROR_WIDTH-1:0]        s1_err;
    logic signed [ERROR_WIDTH:0]          s1_delta;
    logic signed [pidpi_pkg::INTEG_W-1:0] s1_integ;
    logic signed [PA_W-1:0]               s2_a;
    logic signed [PB_W-1:0]               s2_b;
    logic signed [PA_W-1:0]               s2_c;

    // Each stage moves forward when it is empty or the stage after it moves. The
    // sample side still takes beats while a finished beat waits, until the stages fill.
    assign en3    = !v3_reg || result.ready;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign accept = sample.valid && en1;

    assign sample.ready = en1;
    assign result.valid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= sample.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    pidpi_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // The previous sample and, in positional mode, the integrator advance on every
    // accepted beat, so the state recurrence never waits on the products downstream.
    pidpi_state_stage #(
        .ERROR_WIDTH (ERROR_WIDTH)
    ) u_state_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .error  (sample.error),
        .cfg    (regs),
        .err    (s1_err),
        .delta  (s1_delta),
        .integ  (s1_integ)
    );

    pidpi_product_stage #(
        .ERROR_WIDTH (ERROR_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_product_stage (
        .clk    (clk),
        .load   (en2 && v1_reg),
        .cfg    (regs),
        .err    (s1_err),
        .delta  (s1_delta),
        .integ  (s1_integ),
        .term_a (s2_a),
        .term_b (s2_b),
        .term_c (s2_c)
    );

    // The held output is the drive register itself; it only changes on a real beat.
    pidpi_output_stage #(
        .ERROR_WIDTH (ERROR_WIDTH)
    ) u_output_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (en3 && v2_reg),
        .cfg    (regs),
        .term_a (s2_a),
        .term_b (s2_b),
        .term_c (s2_c),
        .drive  (result.drive)
    );

endmodule

FILE: design/pidpi_cfg_regs.sv
// Configuration register file of the PID unit, written through the config channel.
// Depends on pidpi_pkg and pidpi_cfg_if.
module pidpi_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    pidpi_cfg_if.sink         cfg,
    output pidpi_pkg::cfg_t   regs
);

    pidpi_pkg::cfg_t regs_reg;

    // Writes always complete in one beat.
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.mode        <= pidpi_pkg::MODE_POSITIONAL;
            regs_reg.gain_p      <= '0;
            regs_reg.gain_i      <= '0;
            regs_reg.gain_d      <= '0;
            regs_reg.integ_limit <= '0;
            regs_reg.pos_limit   <= pidpi_pkg::POS_LIMIT_RST;
            regs_reg.inc_high    <= pidpi_pkg::INC_HIGH_RST;
            regs_reg.inc_low     <= pidpi_pkg::INC_LOW_RST;
        end
        else if (cfg.valid)
        begin
            unique case (pidpi_pkg::cfg_idx_t'(cfg.index))
                pidpi_pkg::CFG_MODE:
                    regs_reg.mode <= pidpi_pkg::mode_t'(cfg.data[0]);
                pidpi_pkg::CFG_GAIN_P:
                    regs_reg.gain_p <= cfg.data[pidpi_pkg::GAIN_W-1:0];
                pidpi_pkg::CFG_GAIN_I:
                    regs_reg.gain_i <= cfg.data[pidpi_pkg::GAIN_W-1:0];
                pidpi_pkg::CFG_GAIN_D:
                    regs_reg.gain_d <= cfg.data[pidpi_pkg::GAIN_W-1:0];
                pidpi_pkg::CFG_INTEG_LIMIT:
                    regs_reg.integ_limit <= cfg.data[pidpi_pkg::ILIM_W-1:0];
                pidpi_pkg::CFG_POS_LIMIT:
                    regs_reg.pos_limit <= cfg.data[pidpi_pkg::PLIM_W-1:0];
                pidpi_pkg::CFG_INC_HIGH:
                    regs_reg.inc_high <= cfg.data[pidpi_pkg::DRIVE_W-1:0];
                pidpi_pkg::CFG_INC_LOW:
                    regs_reg.inc_low <= cfg.data[pidpi_pkg::DRIVE_W-1:0];
            endcase
        end
    end

endmodule

FILE: design/pidpi_state_stage.sv
// Input stage of the PID unit: registers the sample and its difference, and keeps
// the clamped integrator and the previous sample. Depends on pidpi_pkg.
module pidpi_state_stage #(
    parameter int ERROR_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic signed [ERROR_WIDTH-1:0]        error,
    input  pidpi_pkg::cfg_t                      cfg,
    output logic signed [ERROR_WIDTH-1:0]        err,
    output logic signed [ERROR_WIDTH:0]          delta,
    output logic signed [pidpi_pkg::INTEG_W-1:0] integ
);

    localparam int ISUM_W = pidpi_pkg::INTEG_W + 1;

    logic signed [ERROR_WIDTH-1:0]        err_reg;
    logic signed [ERROR_WIDTH-1:0]        prev_err_reg;
    logic signed [ERROR_WIDTH:0]          delta_reg;
    logic signed [ERROR_WIDTH:0]          delta_next;
    logic signed [pidpi_pkg::INTEG_W-1:0] integ_reg;
    logic signed [pidpi_pkg::INTEG_W-1:0] integ_next;
    logic signed [ISUM_W-1:0]             isum;
    logic signed [ISUM_W-1:0]             ilim_pos;
    logic signed [ISUM_W-1:0]             ilim_neg;

    assign delta_next = (ERROR_WIDTH+1)'(error) - (ERROR_WIDTH+1)'(prev_err_reg);

    // The integrator only moves in positional mode and is held inside +/- limit.
    always_comb
    begin
        isum     = ISUM_W'(integ_reg) + ISUM_W'(error);
        ilim_pos = $signed({2'b00, cfg.integ_limit});
        ilim_neg = -ilim_pos;
        if (cfg.mode == pidpi_pkg::MODE_INCREMENTAL)
            integ_next = integ_reg;
        else if (isum > ilim_pos)
            integ_next = ilim_pos[pidpi_pkg::INTEG_W-1:0];
        else if (isum < ilim_neg)
            integ_next = ilim_neg[pidpi_pkg::INTEG_W-1:0];
        else
            integ_next = isum[pidpi_pkg::INTEG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end
        else if (accept)
        begin
            integ_reg    <= integ_next;
            prev_err_reg <= error;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg   <= error;
            delta_reg <= delta_next;
        end
    end

    assign err   = err_reg;
    assign delta = delta_reg;
    assign integ = integ_reg;

endmodule

FILE: design/pidpi_product_stage.sv
// Multiplier stage of the PID unit: three gain products, each scaled down by the
// fraction bits with a floor shift. Depends on pidpi_pkg.
module pidpi_product_stage #(
    parameter int ERROR_WIDTH = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                 clk,
    input  logic                                 load,
    input  pidpi_pkg::cfg_t                      cfg,
    input  logic signed [ERROR_WIDTH-1:0]        err,
    input  logic signed [ERROR_WIDTH:0]          delta,
    input  logic signed [pidpi_pkg::INTEG_W-1:0] integ,
    output logic signed [pidpi_pkg::GAIN_W+ERROR_WIDTH:0]            term_a,
    output logic signed [pidpi_pkg::GAIN_W+pidpi_pkg::INTEG_W-1:0]   term_b,
    output logic signed [pidpi_pkg::GAIN_W+ERROR_WIDTH:0]            term_c
);

    localparam int PA_W = pidpi_pkg::GAIN_W + ERROR_WIDTH + 1;
    localparam int PB_W = pidpi_pkg::GAIN_W + pidpi_pkg::INTEG_W;

    logic signed [ERROR_WIDTH:0]          op_a;
    logic signed [pidpi_pkg::INTEG_W-1:0] op_b;
    logic signed [PA_W-1:0]               prod_a;
    logic signed [PB_W-1:0]               prod_b;
    logic signed [PA_W-1:0]               prod_c;
    logic signed [PA_W-1:0]               term_a_reg;
    logic signed [PB_W-1:0]               term_b_reg;
    logic signed [PA_W-1:0]               term_c_reg;

    // Positional: Kp*e, Ki*integ, Kd*de. Incremental: Kp*de, Ki*e (Kd unused there).
    always_comb
    begin
        if (cfg.mode == pidpi_pkg::MODE_INCREMENTAL)
        begin
            op_a = delta;
            op_b = pidpi_pkg::INTEG_W'(err);
        end
        else
        begin
            op_a = (ERROR_WIDTH+1)'(err);
            op_b = integ;
        end
        prod_a = PA_W'($signed(cfg.gain_p)) * PA_W'(op_a);
        prod_b = PB_W'($signed(cfg.gain_i)) * PB_W'(op_b);
        prod_c = PA_W'($signed(cfg.gain_d)) * PA_W'(delta);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            term_a_reg <= prod_a >>> FRAC_BITS;
            term_b_reg <= prod_b >>> FRAC_BITS;
            term_c_reg <= prod_c >>> FRAC_BITS;
        end
    end

    assign term_a = term_a_reg;
    assign term_b = term_b_reg;
    assign term_c = term_c_reg;

endmodule

FILE: design/pidpi_output_stage.sv
// Output stage of the PID unit: sums the scaled terms, clamps to the window of the
// active mode and holds the last drive value. Depends on pidpi_pkg.
module pidpi_output_stage #(
    parameter int ERROR_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  pidpi_pkg::cfg_t                      cfg,
    input  logic signed [pidpi_pkg::GAIN_W+ERROR_WIDTH:0]            term_a,
    input  logic signed [pidpi_pkg::GAIN_W+pidpi_pkg::INTEG_W-1:0]   term_b,
    input  logic signed [pidpi_pkg::GAIN_W+ERROR_WIDTH:0]            term_c,
    output logic signed [pidpi_pkg::DRIVE_W-1:0] drive
);

    localparam int PA_W  = pidpi_pkg::GAIN_W + ERROR_WIDTH + 1;
    localparam int PB_W  = pidpi_pkg::GAIN_W + pidpi_pkg::INTEG_W;
    localparam int MAX_W = (PA_W > PB_W) ? PA_W : PB_W;
    localparam int SUM_W = MAX_W + 2;

    logic signed [pidpi_pkg::DRIVE_W-1:0] held_reg;
    logic signed [pidpi_pkg::DRIVE_W-1:0] held_next;
    logic signed [SUM_W-1:0]              third;
    logic signed [SUM_W-1:0]              sum;
    logic signed [SUM_W-1:0]              plim;
    logic signed [SUM_W-1:0]              hi;
    logic signed [SUM_W-1:0]              lo;
    logic signed [SUM_W-1:0]              upper_cut;

    always_comb
    begin
        // In incremental mode the held output takes the place of the derivative term.
        if (cfg.mode == pidpi_pkg::MODE_INCREMENTAL)
            third = SUM_W'(held_reg);
        else
            third = SUM_W'(term_c);
        sum  = SUM_W'(term_a) + SUM_W'(term_b) + third;
        plim = SUM_W'($signed({1'b0, cfg.pos_limit}));
        hi   = SUM_W'(cfg.inc_high);
        lo   = SUM_W'(cfg.inc_low);

        // Upper bound first, lower bound second: an inverted window gives the low bound.
        upper_cut = (sum > hi) ? hi : sum;

        if (cfg.mode == pidpi_pkg::MODE_INCREMENTAL)
            held_next = (upper_cut < lo) ? lo[pidpi_pkg::DRIVE_W-1:0]
                                         : upper_cut[pidpi_pkg::DRIVE_W-1:0];
        else if (sum > plim)
            held_next = plim[pidpi_pkg::DRIVE_W-1:0];
        else if (sum < -plim)
            held_next = -plim[pidpi_pkg::DRIVE_W-1:0];
        else
            held_next = sum[pidpi_pkg::DRIVE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (load)
            held_reg <= held_next;
    end

    assign drive = held_reg;

endmodule

FILE: design/pidpi_checker.sv
// Port-level checks for the PID unit and the bind that attaches them to the top level.
// Depends on pidpi_pkg and pid_position_incremental_unit.
module pidpi_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [pidpi_pkg::DRIVE_W-1:0] drive
);

    // A result beat that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // The drive value of a stalled beat does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(drive))
        else $error("drive changed while stalled");

    // With nothing waiting on the output, the sample side is always open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("sample side blocked with an empty output");

    // An accepted sample beat reaches the output while the result channel stays ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result beat late");

endmodule

bind pid_position_incremental_unit pidpi_checker u_pidpi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .drive     (result.drive)
);
